@@ hdl/depth_test_alpha_blend_rop_macros.svh @@
// assertion macros for the raster operations block
`ifndef DEPTH_TEST_ALPHA_BLEND_ROP_MACROS_SVH
`define DEPTH_TEST_ALPHA_BLEND_ROP_MACROS_SVH
`ifndef SYNTHESIS
`define ROP_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rop check failed");
`define ROP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rop check failed");
`else
`define ROP_ASSERT_NOW(label, ante, cons)
`define ROP_ASSERT_NEXT(label, ante, cons)
`endif
`endif

@@ hdl/rop_pkg.sv @@
// types and constants of the raster operations block
`default_nettype none
package rop_pkg;

  localparam int unsigned FB_WIDTH_DEF  = 256;
  localparam int unsigned FB_HEIGHT_DEF = 256;
  localparam int unsigned CRD_W         = 13;

  localparam logic [1:0] KIND_FRAG  = 2'd0;
  localparam logic [1:0] KIND_PLOT  = 2'd1;
  localparam logic [1:0] KIND_CLEAR = 2'd2;

  localparam logic [1:0] CH_B = 2'd0;
  localparam logic [1:0] CH_G = 2'd1;
  localparam logic [1:0] CH_R = 2'd2;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  x_coord;
    logic [7:0]  y_coord;
    logic [23:0] depth_value;
    logic [31:0] texel;
  } item_t;

  typedef struct packed {
    logic        written;
    logic        out_of_range;
    logic [31:0] pixel_color;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECODE,
    ST_TEST,
    ST_MUL_S,
    ST_MUL_D,
    ST_DIV,
    ST_CLEAR
  } state_t;

endpackage
`default_nettype wire

@@ hdl/depth_test_alpha_blend_rop.sv @@
// raster operations: depth test, alpha blend, plot and clear over color and depth buffers
//
//   channel   signals              handshake
//   item      start, busy, item    beat taken when start high and busy low
//   result    done, result         one-cycle strobe, no back pressure
//
// plot, out of range or unused kind: result set by the decode state
// fragment: finished by the test state on a depth fail; on a pass one 8x8 multiplier and
//   one divide-by-255 adder serve the three channels, each through mul_s, mul_d and div
// clear: the clear state sweeps every address of both buffers, one pixel per
//   cycle through the single write port of each buffer
// buffers are not cleared by reset; busy is low right after reset
`default_nettype none
`include "depth_test_alpha_blend_rop_macros.svh"
module depth_test_alpha_blend_rop
  import rop_pkg::*;
#(
  parameter int unsigned FB_WIDTH  = FB_WIDTH_DEF,
  parameter int unsigned FB_HEIGHT = FB_HEIGHT_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    start,
  output logic         busy,
  input  wire item_t   item,
  output logic         done,
  output result_t      result
);

  localparam int unsigned PIX_COUNT = FB_WIDTH * FB_HEIGHT;
  localparam int unsigned ADDR_W    = (PIX_COUNT > 1) ? $clog2(PIX_COUNT) : 1;
  localparam logic [CRD_W-1:0]  W_LIM     = CRD_W'(FB_WIDTH);
  localparam logic [CRD_W-1:0]  H_LIM     = CRD_W'(FB_HEIGHT);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PIX_COUNT - 1);

  state_t            state, state_next;
  item_t             itm;
  logic [ADDR_W-1:0] addr;
  logic [ADDR_W-1:0] sweep, sweep_next;
  logic [1:0]        chan, chan_next;
  logic [15:0]       acc, acc_next;
  logic [23:0]       blend, blend_next;
  logic              fin;
  result_t           fin_res;

  logic [31:0] color_mem [PIX_COUNT];
  logic [23:0] depth_mem [PIX_COUNT];
  logic [31:0] color_q;
  logic [23:0] depth_q;
  logic        mem_rd;
  logic        color_we, depth_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [31:0] color_wd;
  logic [23:0] depth_wd;

  logic [7:0]  alpha, src_ch, dst_ch, mul_a, mul_b;
  logic [15:0] prod, acc_add, div_sum;
  logic [7:0]  qbyte;
  logic        oor;

  assign busy  = (state != ST_IDLE);
  assign alpha = itm.texel[31:24];

  // shared datapath
  always_comb begin
    case (chan)
      CH_B:    begin src_ch = itm.texel[7:0];   dst_ch = color_q[7:0];   end
      CH_G:    begin src_ch = itm.texel[15:8];  dst_ch = color_q[15:8];  end
      CH_R:    begin src_ch = itm.texel[23:16]; dst_ch = color_q[23:16]; end
      default: begin src_ch = 8'h00;            dst_ch = 8'h00;          end
    endcase
    if (state == ST_MUL_D) begin
      mul_a   = dst_ch;
      mul_b   = 8'hFF - alpha;
      acc_add = acc;
    end else begin
      mul_a   = src_ch;
      mul_b   = alpha;
      acc_add = 16'h0000;
    end
    prod    = 16'(mul_a) * 16'(mul_b);
    div_sum = acc + 16'd1 + {8'h00, acc[15:8]};
    qbyte   = div_sum[15:8];
    oor     = (CRD_W'(itm.x_coord) >= W_LIM) || (CRD_W'(itm.y_coord) >= H_LIM);
  end

  // sequencer
  always_comb begin
    state_next = state;
    sweep_next = sweep;
    chan_next  = chan;
    acc_next   = acc;
    blend_next = blend;
    fin        = 1'b0;
    fin_res    = '0;
    mem_rd     = 1'b0;
    color_we   = 1'b0;
    depth_we   = 1'b0;
    wr_addr    = addr;
    color_wd   = itm.texel;
    depth_wd   = itm.depth_value;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (itm.kind)
          KIND_CLEAR: begin
            sweep_next = '0;
            state_next = ST_CLEAR;
          end
          KIND_PLOT: begin
            fin        = 1'b1;
            state_next = ST_IDLE;
            if (oor) begin
              fin_res.out_of_range = 1'b1;
            end else begin
              color_we            = 1'b1;
              fin_res.written     = 1'b1;
              fin_res.pixel_color = itm.texel;
            end
          end
          KIND_FRAG: begin
            if (oor) begin
              fin                  = 1'b1;
              fin_res.out_of_range = 1'b1;
              state_next           = ST_IDLE;
            end else begin
              mem_rd     = 1'b1;
              state_next = ST_TEST;
            end
          end
          default: begin
            fin        = 1'b1;
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_TEST: begin
        if (depth_q <= itm.depth_value) begin
          chan_next  = CH_R;
          state_next = ST_MUL_S;
        end else begin
          fin                 = 1'b1;
          fin_res.pixel_color = color_q;
          state_next          = ST_IDLE;
        end
      end
      ST_MUL_S: begin
        acc_next   = acc_add + prod;
        state_next = ST_MUL_D;
      end
      ST_MUL_D: begin
        acc_next   = acc_add + prod;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        case (chan)
          CH_R:    blend_next = {qbyte, blend[15:0]};
          CH_G:    blend_next = {blend[23:16], qbyte, blend[7:0]};
          default: blend_next = {blend[23:8], qbyte};
        endcase
        if (chan == CH_B) begin
          color_we            = 1'b1;
          depth_we            = 1'b1;
          color_wd            = {8'h00, blend[23:8], qbyte};
          fin                 = 1'b1;
          fin_res.written     = 1'b1;
          fin_res.pixel_color = {8'h00, blend[23:8], qbyte};
          state_next          = ST_IDLE;
        end else begin
          chan_next  = chan - 2'd1;
          state_next = ST_MUL_S;
        end
      end
      ST_CLEAR: begin
        color_we = 1'b1;
        depth_we = 1'b1;
        wr_addr  = sweep;
        if (sweep == LAST_ADDR) begin
          fin                 = 1'b1;
          fin_res.written     = 1'b1;
          fin_res.pixel_color = itm.texel;
          state_next          = ST_IDLE;
        end else begin
          sweep_next = sweep + ADDR_W'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      itm  <= item;
      addr <= ADDR_W'(ADDR_W'(item.y_coord) * ADDR_W'(FB_WIDTH) + ADDR_W'(item.x_coord));
    end
    sweep <= sweep_next;
    chan  <= chan_next;
    acc   <= acc_next;
    blend <= blend_next;
    if (fin) begin
      result <= fin_res;
    end
  end

  // buffers
  always_ff @(posedge clk) begin
    if (color_we) begin
      color_mem[wr_addr] <= color_wd;
    end
    if (mem_rd) begin
      color_q <= color_mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (depth_we) begin
      depth_mem[wr_addr] <= depth_wd;
    end
    if (mem_rd) begin
      depth_q <= depth_mem[addr];
    end
  end

  `ROP_ASSERT_NOW(a_done_idle, done, !busy)
  `ROP_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `ROP_ASSERT_NEXT(a_sweep_step, state == ST_CLEAR && state_next == ST_CLEAR,
                   sweep == ADDR_W'($past(sweep) + ADDR_W'(1)))
  `ROP_ASSERT_NOW(a_oor_nowrite, done && result.out_of_range, !result.written)
  `ROP_ASSERT_NOW(a_chan_valid, state == ST_MUL_S || state == ST_MUL_D, chan != 2'd3)

endmodule
`default_nettype wire
